// ===== rtl/core/data_run_cluster_mapper_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the data-run cluster mapper
// Concurrent assertion wrappers on clk_i and rst_ni. They expand to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef DATA_RUN_CLUSTER_MAPPER_ASSERT_SVH
`define DATA_RUN_CLUSTER_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define DRCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define DRCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DRCM_ASSERT(lbl, prop, msg)
`define DRCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/drcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Data-run cluster mapper package
// Shared constants, status codes, the parser result type and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package drcm_pkg;

  // Largest byte count that a header nibble may give.
  localparam logic [3:0] MaxFieldBytes = 4'd8;

  typedef enum logic [1:0] {
    StMapped    = 2'd0,
    StUnmapped  = 2'd1,
    StMalformed = 2'd2
  } status_e;

  // One finished list as the parser hands it to the result buffer.
  // The mapped cluster is hit_cur + hit_rel when hit is set.
  typedef struct packed {
    status_e     status;
    logic        hit;
    logic [63:0] hit_cur;
    logic [63:0] hit_rel;
    logic [63:0] total;
  } result_t;

  // Sign-extends an offset of nbytes little-endian bytes (1 to 8) to 64 bits.
  // A count of zero is a sparse run and gives a zero delta.
  function automatic logic [63:0] sext_offset(input logic [63:0] acc,
                                              input logic [3:0]  nbytes);
    logic        sign;
    logic [63:0] res;
    res  = acc;
    sign = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (nbytes == 4'(k + 1)) begin
        sign = acc[8 * k + 7];
      end
    end
    if (nbytes == 4'd0) begin
      res = '0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) >= nbytes) begin
          res[8 * k +: 8] = {8{sign}};
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/drcm_if.sv =====
// ----------------------------------------------------------------------------
// Data-run cluster mapper channels
// Valid/ready channels for list bytes in and mapping results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface drcm_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  run_byte;
  logic        start_req;
  logic [63:0] query_vcn;

  modport source (output valid, run_byte, start_req, query_vcn, input ready);
  modport sink   (input valid, run_byte, start_req, query_vcn, output ready);
endinterface

interface drcm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] mapped_lcn;
  logic [63:0] total_clusters;

  modport source (output valid, status, mapped_lcn, total_clusters, input ready);
  modport sink   (input valid, status, mapped_lcn, total_clusters, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/data_run_cluster_mapper.sv =====
// ----------------------------------------------------------------------------
// Data-run cluster mapper
// Maps a virtual cluster through a data-run list and totals the run lengths.
// ----------------------------------------------------------------------------
// The block reads a data-run list one byte per request and takes a new byte
// in every cycle that ready is high. A request with start_req set begins a
// new list, clears the accumulators and latches query_vcn as the cluster to
// look up. Each run is a header byte (low nibble: length byte count, high
// nibble: offset byte count) followed by the little-endian length and the
// two's complement offset delta; a run with no offset bytes is sparse and
// leaves the cluster where it was. A zero header closes the list and returns
// one result: status mapped with the logical cluster, or not mapped with all
// ones, and the sum of all run lengths. A header nibble above eight returns a
// malformed status and the total so far. After a result, bytes are dropped
// until the next start. The closing byte's result is loaded into the output
// register, or into the skid entry while that register holds a result not
// yet taken. Input bytes keep flowing while a result waits; ready drops only
// while both entries hold a result. All sums wrap modulo 2^64.
// ----------------------------------------------------------------------------
`default_nettype none

module data_run_cluster_mapper import drcm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  drcm_req_if.sink   req_i,
  drcm_res_if.source res_o
);

  logic    in_ready;
  logic    acc;
  logic    emit;
  result_t result;

  // A request is taken whenever the skid entry is free.
  assign req_i.ready = in_ready;
  assign acc         = req_i.valid & in_ready;

  // Byte parser: run fields, cluster accumulators and the hit record.
  drcm_run_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .run_byte_i  (req_i.run_byte),
    .start_req_i (req_i.start_req),
    .query_vcn_i (req_i.query_vcn),
    .emit_o      (emit),
    .res_o       (result)
  );

  // Result side: output register with a one-entry skid behind it.
  drcm_result_buf u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .res_i      (result),
    .in_ready_o (in_ready),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/drcm_run_parser.sv =====
// ----------------------------------------------------------------------------
// Data-run list parser
// Takes one list byte per cycle when acc_i is set, tracks the run fields and
// the cluster accumulators, and flags the byte that closes or breaks the list.
// ----------------------------------------------------------------------------
`default_nettype none
`include "data_run_cluster_mapper_assert.svh"

module drcm_run_parser import drcm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        acc_i,
  input  wire logic [7:0]  run_byte_i,
  input  wire logic        start_req_i,
  input  wire logic [63:0] query_vcn_i,
  output logic             emit_o,
  output result_t          res_o
);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhLength = 2'd1,
    PhOffset = 2'd2,
    PhIdle   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d, phase_cl;
  logic [3:0]  left_q, left_d, left_dec;
  logic [2:0]  idx_q, idx_d;
  logic [3:0]  off_n_q, off_n_d;
  logic [63:0] len_q, len_d, len_full;
  logic [63:0] off_q, off_d, off_full;
  logic [63:0] cur_q, cur_d, cur_cl, cur_new;
  logic [63:0] vstart_q, vstart_d, vstart_cl;
  // rel holds target - run start, so the cover test is one compare.
  logic [63:0] rel_q, rel_d, rel_cl;
  logic        hit_q, hit_d, hit_cl;
  logic [63:0] hit_cur_q, hit_cur_d;
  logic [63:0] hit_rel_q, hit_rel_d;
  logic        finish;
  logic        emit_c;
  logic [3:0]  lnib, onib;

  assign lnib     = run_byte_i[3:0];
  assign onib     = run_byte_i[7:4];
  assign left_dec = left_q - 4'd1;

  // Accumulators with the current byte merged into its lane.
  always_comb begin
    len_full = len_q;
    off_full = off_q;
    if (phase_q == PhLength) begin
      len_full[{idx_q, 3'b000} +: 8] = run_byte_i;
    end
    if (phase_q == PhOffset) begin
      off_full[{idx_q, 3'b000} +: 8] = run_byte_i;
    end
  end

  // A start request clears the list before the byte is looked at.
  assign phase_cl  = start_req_i ? PhHeader : phase_q;
  assign cur_cl    = start_req_i ? 64'd0 : cur_q;
  assign vstart_cl = start_req_i ? 64'd0 : vstart_q;
  assign rel_cl    = start_req_i ? query_vcn_i : rel_q;
  assign hit_cl    = start_req_i ? 1'b0 : hit_q;

  assign cur_new = cur_q + sext_offset(off_full, off_n_q);

  always_comb begin
    phase_d   = phase_cl;
    left_d    = left_q;
    idx_d     = idx_q;
    off_n_d   = off_n_q;
    len_d     = len_q;
    off_d     = off_q;
    cur_d     = cur_cl;
    vstart_d  = vstart_cl;
    rel_d     = rel_cl;
    hit_d     = hit_cl;
    hit_cur_d = hit_cur_q;
    hit_rel_d = hit_rel_q;
    finish    = 1'b0;
    emit_c    = 1'b0;
    res_o.status  = hit_cl ? StMapped : StUnmapped;
    res_o.hit     = hit_cl;
    res_o.hit_cur = hit_cur_q;
    res_o.hit_rel = hit_rel_q;
    res_o.total   = vstart_cl;

    unique case (phase_cl)
      PhHeader: begin
        if (run_byte_i == 8'd0) begin
          emit_c  = 1'b1;
          phase_d = PhIdle;
        end else if (lnib > MaxFieldBytes || onib > MaxFieldBytes) begin
          emit_c       = 1'b1;
          res_o.status = StMalformed;
          res_o.hit    = 1'b0;
          phase_d      = PhIdle;
        end else begin
          len_d   = '0;
          off_d   = '0;
          idx_d   = '0;
          off_n_d = onib;
          if (lnib != 4'd0) begin
            left_d  = lnib;
            phase_d = PhLength;
          end else begin
            left_d  = onib;
            phase_d = PhOffset;
          end
        end
      end
      PhLength: begin
        len_d  = len_full;
        idx_d  = idx_q + 3'd1;
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          if (off_n_q == 4'd0) begin
            finish = 1'b1;
          end else begin
            left_d  = off_n_q;
            idx_d   = '0;
            phase_d = PhOffset;
          end
        end
      end
      PhOffset: begin
        off_d  = off_full;
        idx_d  = idx_q + 3'd1;
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          finish = 1'b1;
        end
      end
      PhIdle: begin
      end
      default: begin
      end
    endcase

    // Close the run: move the cluster, test the cover, advance the start.
    if (finish) begin
      cur_d = cur_new;
      if (!hit_q && (rel_q < len_full)) begin
        hit_d     = 1'b1;
        hit_cur_d = cur_new;
        hit_rel_d = rel_q;
      end
      rel_d    = rel_q - len_full;
      vstart_d = vstart_q + len_full;
      len_d    = '0;
      off_d    = '0;
      idx_d    = '0;
      left_d   = '0;
      phase_d  = PhHeader;
    end
  end

  assign emit_o = acc_i & emit_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      left_q    <= '0;
      idx_q     <= '0;
      off_n_q   <= '0;
      len_q     <= '0;
      off_q     <= '0;
      cur_q     <= '0;
      vstart_q  <= '0;
      rel_q     <= '0;
      hit_q     <= 1'b0;
      hit_cur_q <= '0;
      hit_rel_q <= '0;
    end else if (acc_i) begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      off_n_q   <= off_n_d;
      len_q     <= len_d;
      off_q     <= off_d;
      cur_q     <= cur_d;
      vstart_q  <= vstart_d;
      rel_q     <= rel_d;
      hit_q     <= hit_d;
      hit_cur_q <= hit_cur_d;
      hit_rel_q <= hit_rel_d;
    end
  end

  `DRCM_ASSERT(a_emit_goes_idle, emit_o |=> phase_q == PhIdle, "no idle after result")
  `DRCM_ASSERT(a_idle_is_silent, phase_q == PhIdle && !start_req_i |-> !emit_o, "idle result")
  `DRCM_ASSERT(a_hit_sticks, hit_q && !(acc_i && start_req_i) |=> hit_q, "hit lost")

endmodule

`default_nettype wire

// ===== rtl/core/drcm_result_buf.sv =====
// ----------------------------------------------------------------------------
// Result buffer
// Output register plus one skid entry for finished lists. Forms the mapped
// cluster on the way into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "data_run_cluster_mapper_assert.svh"

module drcm_result_buf import drcm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    emit_i,
  input  wire result_t res_i,
  output logic         in_ready_o,
  drcm_res_if.source   res_o
);

  logic        out_vld_q, out_vld_d;
  status_e     status_q;
  logic [63:0] lcn_q, total_q;
  logic        skid_vld_q, skid_vld_d;
  result_t     skid_q;
  result_t     src;
  logic        pop;
  logic        load_out;
  logic        load_skid;

  assign pop        = out_vld_q & res_o.ready;
  assign in_ready_o = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    src        = res_i;
    if (skid_vld_q) begin
      src = skid_q;
    end
    if (skid_vld_q) begin
      if (pop) begin
        load_out   = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (emit_i) begin
      if (!out_vld_q || pop) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= src.status;
      lcn_q    <= src.hit ? (src.hit_cur + src.hit_rel) : '1;
      total_q  <= src.total;
    end
    if (load_skid) begin
      skid_q <= res_i;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.status         = status_q;
  assign res_o.mapped_lcn     = lcn_q;
  assign res_o.total_clusters = total_q;

  `DRCM_ASSERT_ALWAYS(a_no_overrun, emit_i |-> !skid_vld_q, "result into a full buffer")
  `DRCM_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q, "skid ahead of output")
  `DRCM_ASSERT(a_unmapped_ones, out_vld_q && status_q != StMapped |-> lcn_q == '1,
               "unmapped cluster not all ones")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Data-run cluster mapper testbench
// Streams data-run lists into the mapper over its request channel. A
// behavioral walker predicts the status, mapped cluster and run total of each
// list, and every returned result is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import drcm_pkg::*;

  // The watchdog gives up after this many cycles in which neither channel
  // moves anything. The longest legal quiet stretch is the forced receiver
  // hold-off below, so this leaves ample margin.
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned SettleCycles = 4;

  // Parser phases of the behavioral walker.
  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhOffset,
    PhIdle
  } walk_phase_e;

  // One predicted lookup result.
  typedef struct packed {
    status_e     status;
    logic [63:0] lcn;
    logic [63:0] total;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  drcm_req_if byte_ch ();
  drcm_res_if result_ch ();

  data_run_cluster_mapper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (byte_ch),
    .res_o  (result_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictions wait here, oldest first, until the block returns them.
  lookup_t pending_lookups[$];

  int unsigned mismatches  = 0;
  int unsigned walked_reqs = 0;  // requests that the parser does not just drop
  int unsigned quiet_cycles = 0;
  int unsigned hold_off_cycles = 0;
  bit          src_gaps  = 1'b0;
  bit          sink_gaps = 1'b0;

  // Bytes of the list being built for the next random request sequence.
  logic [7:0]  list_buf[$];
  logic [63:0] list_span;

  // --------------------------------------------------------------------------
  // Behavioral walker. It mirrors the parser state: the phase, the bytes
  // still to come in the current field, the byte position, the offset byte
  // count of the current run, both field accumulators, the running absolute
  // cluster, the virtual start of the current run (which is also the running
  // total), the latched target and the first hit.
  // --------------------------------------------------------------------------
  walk_phase_e walk_phase;
  logic [3:0]  walk_left;
  logic [2:0]  walk_idx;
  logic [3:0]  walk_off_n;
  logic [63:0] walk_len;
  logic [63:0] walk_off;
  logic [63:0] walk_lcn;
  logic [63:0] walk_vcn;
  logic [63:0] walk_target;
  logic        walk_hit;
  logic [63:0] walk_hit_lcn;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_walk();
    walk_phase   = PhHeader;
    walk_left    = '0;
    walk_idx     = '0;
    walk_off_n   = '0;
    walk_len     = '0;
    walk_off     = '0;
    walk_lcn     = '0;
    walk_vcn     = '0;
    walk_hit     = 1'b0;
    walk_hit_lcn = '1;
  endfunction

  // Two's complement delta of an n-byte offset field; no bytes means a
  // sparse run that leaves the cluster where it was.
  function automatic logic [63:0] offset_delta(input logic [63:0] acc,
                                               input logic [3:0]  n);
    logic [63:0] d;
    int          bits;
    if (n == 4'd0) return '0;
    d    = acc;
    bits = 8 * int'(n);
    if (bits < 64 && d[bits - 1]) d = d | ({64{1'b1}} << bits);
    return d;
  endfunction

  // Closes a run: moves the cluster, records the first covering run and
  // advances the virtual start. The coverage test wraps modulo 2^64.
  function automatic void close_run();
    walk_lcn = walk_lcn + offset_delta(walk_off, walk_off_n);
    if (!walk_hit && (walk_target - walk_vcn) < walk_len) begin
      walk_hit     = 1'b1;
      walk_hit_lcn = walk_lcn + (walk_target - walk_vcn);
    end
    walk_vcn   = walk_vcn + walk_len;
    walk_len   = '0;
    walk_off   = '0;
    walk_idx   = '0;
    walk_left  = '0;
    walk_phase = PhHeader;
  endfunction

  function automatic void post_lookup(input status_e st, input logic [63:0] lcn);
    lookup_t r;
    r.status = st;
    r.lcn    = lcn;
    r.total  = walk_vcn;
    pending_lookups.push_back(r);
    walk_phase = PhIdle;
  endfunction

  // Applies one accepted request to the walker.
  function automatic void walk_run_byte(input logic [7:0]  data,
                                        input logic        first,
                                        input logic [63:0] vcn);
    if (first || walk_phase != PhIdle) walked_reqs++;
    if (first) begin
      clear_walk();
      walk_target = vcn;
    end
    case (walk_phase)
      PhHeader: begin
        if (data == 8'h00) begin
          post_lookup(walk_hit ? StMapped : StUnmapped, walk_hit ? walk_hit_lcn : '1);
        end else if (data[3:0] > MaxFieldBytes || data[7:4] > MaxFieldBytes) begin
          post_lookup(StMalformed, '1);
        end else begin
          walk_len   = '0;
          walk_off   = '0;
          walk_idx   = '0;
          walk_off_n = data[7:4];
          if (data[3:0] != 4'd0) begin
            walk_left  = data[3:0];
            walk_phase = PhLength;
          end else begin
            walk_left  = data[7:4];
            walk_phase = PhOffset;
          end
        end
      end
      PhLength: begin
        walk_len  = walk_len | (64'(data) << (8 * walk_idx));
        walk_idx  = walk_idx + 3'd1;
        walk_left = walk_left - 4'd1;
        if (walk_left == 4'd0) begin
          if (walk_off_n == 4'd0) begin
            close_run();
          end else begin
            walk_left  = walk_off_n;
            walk_idx   = '0;
            walk_phase = PhOffset;
          end
        end
      end
      PhOffset: begin
        walk_off  = walk_off | (64'(data) << (8 * walk_idx));
        walk_idx  = walk_idx + 3'd1;
        walk_left = walk_left - 4'd1;
        if (walk_left == 4'd0) close_run();
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Payload changes at the falling edge; acceptance is seen at
  // the rising edge. valid is left high after a request so that back-to-back
  // requests need no second assignment in one time step; whoever stops
  // sending calls stop_requests first.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic first,
                           input logic [63:0] vcn);
    @(negedge clk_i);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.run_byte  <= 8'($urandom);
      byte_ch.start_req <= 1'($urandom);
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.run_byte  <= data;
    byte_ch.start_req <= first;
    byte_ch.query_vcn <= vcn;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    walk_run_byte(data, first, vcn);
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
  endtask

  // Holds the sender back until every predicted result has come, then lets
  // the pipeline settle.
  task automatic drain_results();
    stop_requests();
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side. ready idles in random bursts, or is held low for a long
  // stretch when hold_off_cycles is set.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk_i);
        hold_off_cycles = 0;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Every returned result is compared, field by field, with the oldest
  // prediction.
  always @(posedge clk_i) begin : result_check
    lookup_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d lcn %h total %h",
                   result_ch.status, result_ch.mapped_lcn, result_ch.total_clusters);
      end else begin
        want = pending_lookups.pop_front();
        if (result_ch.status !== want.status || result_ch.mapped_lcn !== want.lcn ||
            result_ch.total_clusters !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d lcn %h/%h total %h/%h (expected/actual)",
                     want.status, result_ch.status, want.lcn, result_ch.mapped_lcn,
                     want.total, result_ch.total_clusters);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("testbench failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // A list right after reset with no start: the target is cluster 0, which
  // the first run maps to 0x10.
  task automatic test_no_start();
    send_byte(8'h11, 1'b0, rand64());
    send_byte(8'h05, 1'b0, rand64());
    send_byte(8'h10, 1'b0, rand64());
    send_byte(8'h00, 1'b0, rand64());
    drain_results();
  endtask

  // A low nibble above eight, a dropped byte while idle, and a high nibble
  // above eight.
  task automatic test_malformed_and_idle();
    send_byte(8'h09, 1'b1, rand64());
    send_byte(8'hFF, 1'b0, rand64());
    send_byte(8'hA3, 1'b1, rand64());
    drain_results();
  endtask

  // A sparse run, a zero-length run with a negative one-byte delta, and a
  // run that covers the target after the cluster has moved back and forth.
  task automatic test_sparse_and_negative();
    send_byte(8'h01, 1'b1, 64'd5);
    send_byte(8'h04, 1'b0, rand64());
    send_byte(8'h10, 1'b0, rand64());
    send_byte(8'hFF, 1'b0, rand64());
    send_byte(8'h11, 1'b0, rand64());
    send_byte(8'h03, 1'b0, rand64());
    send_byte(8'h20, 1'b0, rand64());
    send_byte(8'h00, 1'b0, rand64());
    drain_results();
  endtask

  // A start in the middle of a run drops it; the new list is empty.
  task automatic test_mid_list_start();
    send_byte(8'h21, 1'b1, rand64());
    send_byte(8'h07, 1'b0, rand64());
    send_byte(8'h00, 1'b1, 64'd0);
    drain_results();
  endtask

  // An eight-byte all-ones length and a most negative one-byte offset, then
  // a run that wraps the virtual space and covers the target a second time,
  // so the first covering run must win and the total wraps.
  task automatic test_wide_fields();
    send_byte(8'h18, 1'b1, 64'd0);
    repeat (8) send_byte(8'hFF, 1'b0, rand64());
    send_byte(8'h80, 1'b0, rand64());
    send_byte(8'h01, 1'b0, rand64());
    send_byte(8'h02, 1'b0, rand64());
    send_byte(8'h00, 1'b0, rand64());
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Random lists.
  // --------------------------------------------------------------------------

  // Byte counts are mostly small so that queries land inside the list;
  // now and then a field is wide.
  function automatic logic [3:0] pick_count();
    if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, 2));
    return 4'($urandom_range(3, 8));
  endfunction

  function automatic void add_run(input logic [3:0] len_n, input logic [3:0] off_n,
                                  input logic [63:0] len_v, input logic [63:0] off_v);
    list_buf.push_back({off_n, len_n});
    for (int k = 0; k < int'(len_n); k++) list_buf.push_back(len_v[8 * k +: 8]);
    for (int k = 0; k < int'(off_n); k++) list_buf.push_back(off_v[8 * k +: 8]);
    if (len_n == 4'd8) list_span = list_span + len_v;
    else list_span = list_span + (len_v & ((64'd1 << (8 * len_n)) - 64'd1));
  endfunction

  // Builds and sends one list. Most end with a zero header; some end on a
  // malformed header and some are cut short and left for the next start.
  task automatic send_random_list();
    logic [3:0]  len_n;
    logic [3:0]  off_n;
    logic [63:0] vcn;
    logic [7:0]  bad;
    int          pick;
    int          keep;
    list_buf.delete();
    list_span = '0;
    repeat ($urandom_range(1, 4)) begin
      len_n = pick_count();
      off_n = pick_count();
      if (len_n == 4'd0 && off_n == 4'd0) len_n = 4'd1;
      add_run(len_n, off_n, rand64(), rand64());
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) vcn = (list_span == 0) ? rand64() : rand64() % list_span;
    else if (pick == 7) vcn = list_span;
    else if (pick == 8) vcn = rand64();
    else vcn = '0;

    pick = $urandom_range(0, 19);
    if (pick >= 18) begin
      keep = $urandom_range(1, list_buf.size());
      while (list_buf.size() > keep) void'(list_buf.pop_back());
    end else if (pick >= 16) begin
      bad = 8'($urandom);
      if ($urandom_range(0, 1) == 0) bad[7:4] = 4'($urandom_range(9, 15));
      else bad[3:0] = 4'($urandom_range(9, 15));
      list_buf.push_back(bad);
    end else begin
      list_buf.push_back(8'h00);
    end

    foreach (list_buf[k]) send_byte(list_buf[k], k == 0, k == 0 ? vcn : rand64());
    // Stray bytes after the list, mostly dropped while the parser idles,
    // occasionally a start on a random byte.
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, rand64());
    if ($urandom_range(0, 19) == 0) send_byte(8'($urandom), 1'b1, rand64());
  endtask

  task automatic test_random_lists(input int unsigned upto, input bit gaps);
    src_gaps  = gaps;
    sink_gaps = gaps;
    while (walked_reqs < upto) send_random_list();
    drain_results();
  endtask

  // The receiver holds off for a long stretch while one-byte lists keep
  // coming, so both result slots fill and the block must stall its input.
  task automatic test_backpressure();
    src_gaps        = 1'b0;
    hold_off_cycles = HoldOffLen;
    repeat (24) send_byte(8'h00, 1'b1, rand64());
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.run_byte  = '0;
    byte_ch.start_req = 1'b0;
    byte_ch.query_vcn = '0;
    clear_walk();
    walk_target = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_no_start();
    test_malformed_and_idle();
    test_sparse_and_negative();
    test_mid_list_start();
    test_wide_fields();
    test_random_lists(900, 1'b1);
    test_backpressure();
    test_random_lists(1500, 1'b1);
    // The last part of the run streams with no idling on either side.
    test_random_lists(1950, 1'b0);

    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/drcm_pkg.sv
rtl/core/drcm_if.sv
rtl/core/drcm_run_parser.sv
rtl/core/drcm_result_buf.sv
rtl/core/data_run_cluster_mapper.sv
test/testbench.sv
